>>> sv/csfp_pkg.sv
// Shared types, codes and saturating helpers for the call-stack profiler.
// No dependencies.
package csfp_pkg;

  typedef enum logic [1:0] {
    OP_CALL = 2'd0,
    OP_TAIL = 2'd1,
    OP_RET  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [63:0] self_time;
    logic [63:0] total_time;
    logic [63:0] self_start;
    logic [63:0] total_start;
    logic [63:0] mem_total;
    logic [63:0] mem_start;
    logic [15:0] depth;
  } prof_rec_t;

  localparam int unsigned RecW = $bits(prof_rec_t);

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] rise64(input logic [63:0] from, input logic [63:0] to);
    return (to > from) ? (to - from) : 64'd0;
  endfunction

endpackage

>>> sv/csfp_chan_if.sv
// Event and result channel interfaces (valid/ready, one beat per item).
// No dependencies.
interface csfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  func_id;
  logic [63:0] timestamp_ns;
  logic [63:0] memory_bytes;
  modport source (output valid, op, func_id, timestamp_ns, memory_bytes, input ready);
  modport sink   (input valid, op, func_id, timestamp_ns, memory_bytes, output ready);
endinterface

interface csfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  rec_id;
  logic [31:0] call_total;
  logic [63:0] self_time_ns;
  logic [63:0] total_time_ns;
  logic [63:0] memory_growth;
  logic [6:0]  stack_level;
  modport source (output valid, status, rec_id, call_total, self_time_ns, total_time_ns,
                  memory_growth, stack_level, input ready);
  modport sink   (input valid, status, rec_id, call_total, self_time_ns, total_time_ns,
                  memory_growth, stack_level, output ready);
endinterface

>>> sv/csfp_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module csfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/call_stack_function_profiler_top.sv
// Call-stack function profiler top level: sequencer, stack RAM, record RAM.
// Depends on csfp_pkg, csfp_chan_if, csfp_ram.
//
//   channel   dir  beat contents
//   in_chan   in   op, func_id, timestamp_ns, memory_bytes
//   out_chan  out  status, rec_id, call_total, self_time_ns, total_time_ns,
//                  memory_growth, stack_level
//
// A read or any event on an empty stack makes only the second pass, on the named
// record; a return that empties the stack makes only the first, on the old top;
// other events make two read-modify-write passes through the record RAM.
// After reset a clearing pass zeroes the records; no event is taken meanwhile. A
// finished beat waits in the output register while the next event is accepted;
// only the final load waits on out_chan.ready.
module call_stack_function_profiler_top #(
  parameter int unsigned FUNC_COUNT  = 256,
  parameter int unsigned STACK_DEPTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  csfp_in_if.sink     in_chan,
  csfp_out_if.source  out_chan
);

  localparam int unsigned FIDW = $clog2(FUNC_COUNT);
  localparam int unsigned SAW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_TOPA, S_TOPR, S_TOPW, S_ISS, S_MOD, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    K_REPORT, K_PUSH, K_RESUME
  } kind_t;

  state_t               state_r;
  kind_t                kind_r;
  csfp_pkg::op_t        op_r;
  csfp_pkg::status_t    status_r;
  logic [FIDW-1:0]      top_r, newtop_r, sec_r, rep_id_r, clr_r;
  logic [63:0]          ts_r, mem_r, dt_r, dm_r, dtot_r;
  logic [SPW-1:0]       sp_r;
  csfp_pkg::prof_rec_t  rec_r, rep_r, upd, mod;

  logic                 out_valid_r;
  csfp_pkg::status_t    out_status_r;
  logic [7:0]           out_id_r;
  logic [31:0]          out_calls_r;
  logic [63:0]          out_self_r, out_total_r, out_mem_r;
  logic [6:0]           out_level_r;

  logic [FIDW-1:0]      fid_tbl [256];
  logic [FIDW-1:0]      stk_rdata, stk_wdata;
  logic [SAW-1:0]       stk_raddr, stk_waddr;
  logic                 stk_we;
  logic [FIDW-1:0]      rec_raddr, rec_waddr;
  logic [csfp_pkg::RecW-1:0] rec_rdata, rec_wdata;
  logic                 rec_we;
  logic                 pop, ovf, accept, out_load;
  logic [SPW-1:0]       sp_m1, sp_m2;

  for (genvar g = 0; g < 256; g++) begin : g_fid
    assign fid_tbl[g] = FIDW'(g % FUNC_COUNT);
  end

  csfp_ram #(.WIDTH(FIDW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  csfp_ram #(.WIDTH(csfp_pkg::RecW), .DEPTH(FUNC_COUNT)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);
  assign sp_m1    = sp_r - SPW'(1);
  assign sp_m2    = sp_r - SPW'(2);
  assign pop      = (op_r != csfp_pkg::OP_CALL);
  assign ovf      = (op_r == csfp_pkg::OP_CALL) && (sp_r >= SPW'(STACK_DEPTH));

  // charge and pop of the old top, restart of its start marks on overflow
  always_comb begin
    upd = rec_r;
    upd.self_time = csfp_pkg::sat_add64(rec_r.self_time, dt_r);
    upd.mem_total = csfp_pkg::sat_add64(rec_r.mem_total, dm_r);
    if (pop) begin
      if (rec_r.depth != 16'd0) begin
        upd.depth = rec_r.depth - 16'd1;
      end
      if (upd.depth == 16'd0) begin
        upd.total_time = csfp_pkg::sat_add64(rec_r.total_time, dtot_r);
      end
    end
    if (ovf) begin
      upd.self_start = ts_r;
      upd.mem_start  = mem_r;
    end
  end

  // second record: resume, push or plain report
  always_comb begin
    mod = rec_rdata;
    if (kind_r != K_REPORT) begin
      mod.self_start = ts_r;
      mod.mem_start  = mem_r;
    end
    if (kind_r == K_PUSH) begin
      if (mod.depth == 16'd0) begin
        mod.total_start = ts_r;
      end
      if (mod.depth != 16'hFFFF) begin
        mod.depth = mod.depth + 16'd1;
      end
      if (mod.calls != 32'hFFFF_FFFF) begin
        mod.calls = mod.calls + 32'd1;
      end
    end
  end

  always_comb begin
    stk_raddr = (state_r == S_TOPA) ? sp_m2[SAW-1:0] : sp_m1[SAW-1:0];
    stk_we    = (state_r == S_MOD) && (kind_r == K_PUSH);
    stk_waddr = sp_r[SAW-1:0];
    stk_wdata = sec_r;
    rec_raddr = (state_r == S_TOPA) ? stk_rdata : sec_r;
    rec_we    = 1'b0;
    rec_waddr = sec_r;
    rec_wdata = mod;
    unique case (state_r)
      S_CLR: begin
        rec_we    = 1'b1;
        rec_waddr = clr_r;
        rec_wdata = '0;
      end
      S_TOPW: begin
        rec_we    = 1'b1;
        rec_waddr = top_r;
        rec_wdata = upd;
      end
      S_MOD: begin
        rec_we = (kind_r != K_REPORT);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + FIDW'(1);
          if (clr_r == FIDW'(FUNC_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r     <= csfp_pkg::op_t'(in_chan.op);
            sec_r    <= fid_tbl[in_chan.func_id];
            ts_r     <= in_chan.timestamp_ns;
            mem_r    <= in_chan.memory_bytes;
            status_r <= csfp_pkg::ST_OK;
            kind_r   <= K_REPORT;
            priority if (in_chan.op == csfp_pkg::OP_RET && sp_r == '0) begin
              status_r <= csfp_pkg::ST_EMPTY;
              state_r  <= S_ISS;
            end else if (in_chan.op == csfp_pkg::OP_READ) begin
              state_r <= S_ISS;
            end else if (sp_r != '0) begin
              state_r <= S_TOPA;
            end else begin
              kind_r  <= K_PUSH;
              state_r <= S_ISS;
            end
          end
        end
        S_TOPA: begin
          top_r   <= stk_rdata;
          state_r <= S_TOPR;
        end
        S_TOPR: begin
          rec_r    <= csfp_pkg::prof_rec_t'(rec_rdata);
          newtop_r <= stk_rdata;
          dt_r     <= csfp_pkg::rise64(rec_rdata[271:208], ts_r);
          dm_r     <= csfp_pkg::rise64(rec_rdata[79:16], mem_r);
          dtot_r   <= csfp_pkg::rise64(rec_rdata[207:144], ts_r);
          state_r  <= S_TOPW;
        end
        S_TOPW: begin
          if (pop) begin
            sp_r <= sp_m1;
          end
          priority if (op_r == csfp_pkg::OP_RET) begin
            rep_r    <= upd;
            rep_id_r <= top_r;
            if (sp_r > SPW'(1)) begin
              kind_r  <= K_RESUME;
              sec_r   <= newtop_r;
              state_r <= S_ISS;
            end else begin
              state_r <= S_OUT;
            end
          end else if (ovf) begin
            status_r <= csfp_pkg::ST_OVERFLOW;
            kind_r   <= K_REPORT;
            state_r  <= S_ISS;
          end else begin
            kind_r  <= K_PUSH;
            state_r <= S_ISS;
          end
        end
        S_ISS: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (kind_r != K_RESUME) begin
            rep_r    <= mod;
            rep_id_r <= sec_r;
          end
          if (kind_r == K_PUSH) begin
            sp_r <= sp_r + SPW'(1);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_id_r     <= 8'(rep_id_r);
            out_calls_r  <= rep_r.calls;
            out_self_r   <= rep_r.self_time;
            out_total_r  <= rep_r.total_time;
            out_mem_r    <= rep_r.mem_total;
            out_level_r  <= 7'(sp_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.rec_id        = out_id_r;
  assign out_chan.call_total    = out_calls_r;
  assign out_chan.self_time_ns  = out_self_r;
  assign out_chan.total_time_ns = out_total_r;
  assign out_chan.memory_growth = out_mem_r;
  assign out_chan.stack_level   = out_level_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> sp_r < SPW'(STACK_DEPTH))
    else $error("push onto full stack");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result beat without sequencer");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("event accepted but sequencer idle");

endmodule

>>> tb/csfp_tb_pkg.sv
`timescale 1ns / 100ps
// Shared beat types for the profiler testbench.
// Depends on csfp_pkg.
package csfp_tb_pkg;
  import csfp_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [7:0]  func_id;
    logic [63:0] timestamp_ns;
    logic [63:0] memory_bytes;
  } event_beat_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  rec_id;
    logic [31:0] call_total;
    logic [63:0] self_time_ns;
    logic [63:0] total_time_ns;
    logic [63:0] memory_growth;
    logic [6:0]  stack_level;
  } record_beat_t;
endpackage

>>> tb/csfp_checker.sv
`timescale 1ns / 100ps
// Profiler checker: mirrors the call stack and function records, predicts each
// record beat from accepted events and compares. Depends on csfp_pkg, csfp_tb_pkg.
module csfp_checker #(
  parameter int unsigned FUNC_COUNT  = 256,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  csfp_in_if    in_mon,
  csfp_out_if   out_mon,
  output int    fail_count,
  output int    pending,
  output int    beats_seen
);
  import csfp_pkg::*;
  import csfp_tb_pkg::*;

  logic [7:0]  stk [STACK_DEPTH];
  int unsigned sp;
  logic [31:0] calls [FUNC_COUNT];
  logic [63:0] self_t [FUNC_COUNT];
  logic [63:0] tot_t [FUNC_COUNT];
  logic [63:0] self_s [FUNC_COUNT];
  logic [63:0] tot_s [FUNC_COUNT];
  logic [63:0] mem_t [FUNC_COUNT];
  logic [63:0] mem_s [FUNC_COUNT];
  logic [15:0] depth [FUNC_COUNT];
  record_beat_t expected_records [$];

  function automatic logic [63:0] plus_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] gain(logic [63:0] from, logic [63:0] to);
    return (to > from) ? to - from : 64'd0;
  endfunction

  function automatic record_beat_t profile_event(event_beat_t ev);
    record_beat_t r;
    int unsigned f, top, rec;
    bit have_top;
    f = ev.func_id % FUNC_COUNT;
    rec = f;
    r.status = ST_OK;
    top = 0;
    have_top = 0;
    if (ev.op == OP_RET && sp == 0) begin
      r.status = ST_EMPTY;
    end else if (ev.op != OP_READ) begin
      if (sp > 0) begin
        have_top = 1;
        top = stk[sp-1] % FUNC_COUNT;
        self_t[top] = plus_sat(self_t[top], gain(self_s[top], ev.timestamp_ns));
        mem_t[top] = plus_sat(mem_t[top], gain(mem_s[top], ev.memory_bytes));
        if (ev.op == OP_TAIL || ev.op == OP_RET) begin
          if (depth[top] > 0) depth[top]--;
          if (depth[top] == 0) tot_t[top] = plus_sat(tot_t[top], gain(tot_s[top], ev.timestamp_ns));
          sp--;
          have_top = 0;
        end
      end
      if (ev.op == OP_RET) begin
        rec = top;
        if (sp > 0) begin
          self_s[stk[sp-1] % FUNC_COUNT] = ev.timestamp_ns;
          mem_s[stk[sp-1] % FUNC_COUNT] = ev.memory_bytes;
        end
      end else if (sp >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
        if (have_top) begin
          self_s[top] = ev.timestamp_ns;
          mem_s[top] = ev.memory_bytes;
        end
      end else begin
        stk[sp] = 8'(f);
        sp++;
        self_s[f] = ev.timestamp_ns;
        mem_s[f] = ev.memory_bytes;
        if (depth[f] == 0) tot_s[f] = ev.timestamp_ns;
        if (depth[f] != 16'hFFFF) depth[f]++;
        if (calls[f] != 32'hFFFF_FFFF) calls[f]++;
      end
    end
    r.rec_id = rec[7:0];
    r.call_total = calls[rec];
    r.self_time_ns = self_t[rec];
    r.total_time_ns = tot_t[rec];
    r.memory_growth = mem_t[rec];
    r.stack_level = sp[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    event_beat_t ev;
    record_beat_t got, want;
    if (!rst_n) begin
      sp = 0;
      for (int i = 0; i < FUNC_COUNT; i++) begin
        calls[i] = '0; self_t[i] = '0; tot_t[i] = '0; self_s[i] = '0;
        tot_s[i] = '0; mem_t[i] = '0; mem_s[i] = '0; depth[i] = '0;
      end
      expected_records.delete();
      fail_count = 0;
      beats_seen = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        ev = {in_mon.op, in_mon.func_id, in_mon.timestamp_ns, in_mon.memory_bytes};
        expected_records.push_back(profile_event(ev));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.rec_id, out_mon.call_total, out_mon.self_time_ns,
               out_mon.total_time_ns, out_mon.memory_growth, out_mon.stack_level};
        beats_seen++;
        if (expected_records.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected record beat %p", got);
        end else begin
          want = expected_records.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("record mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
    end
    pending = expected_records.size();
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Profiler testbench top: clock, reset, event stimulus with random gaps and
// stalls, verdict. Depends on csfp_pkg, csfp_tb_pkg, csfp_chan_if, csfp_checker and the profiler top.
module tb_top;
  import csfp_pkg::*;
  import csfp_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending, beats_seen;
  int   n_events;
  logic [63:0] clock_ns, mem_now;
  int   level;

  csfp_in_if  in_chan ();
  csfp_out_if out_chan ();

  call_stack_function_profiler_top dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  csfp_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .fail_count(fail_count), .pending(pending), .beats_seen(beats_seen)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side stall per beat
  initial begin
    int w;
    out_chan.ready = 0;
    @(negedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      repeat (w) @(negedge clk);
      out_chan.ready = 1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      @(negedge clk);
      out_chan.ready = 0;
    end
  end

  task automatic send_event(op_t op, logic [7:0] fid, logic [63:0] ts, logic [63:0] mem,
                            bit no_gap = 0);
    int w;
    w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    repeat (w) @(negedge clk);
    in_chan.valid = 1;
    in_chan.op = op;
    in_chan.func_id = fid;
    in_chan.timestamp_ns = ts;
    in_chan.memory_bytes = mem;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    in_chan.valid = 0;
    n_events++;
    if (op == OP_CALL || op == OP_TAIL) begin
      if (level < 64 || op == OP_TAIL) level = (op == OP_TAIL && level > 0) ? level : level + 1;
    end else if (op == OP_RET && level > 0) begin
      level--;
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic step_clock();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) clock_ns = clock_ns - $urandom_range(0, 1000);
    else if (k == 1) clock_ns = rand64();
    else clock_ns = clock_ns + $urandom_range(0, 5000);
    k = $urandom_range(0, 7);
    if (k == 0) mem_now = mem_now - $urandom_range(0, 4096);
    else if (k == 1) mem_now = rand64();
    else mem_now = mem_now + $urandom_range(0, 4096);
  endtask

  initial begin
    int k, burst;
    logic [7:0] fid;
    n_events = 0;
    level = 0;
    clock_ns = 0;
    mem_now = 0;
    rst_n = 0;
    in_chan.valid = 0;
    in_chan.op = OP_CALL;
    in_chan.func_id = '0;
    in_chan.timestamp_ns = '0;
    in_chan.memory_bytes = '0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // directed: empty return, extremes, read, wrap-around times, saturation
    send_event(OP_RET, 8'hFF, '0, '0);
    send_event(OP_READ, 8'h00, '1, '1);
    send_event(OP_TAIL, 8'hFF, 64'd100, 64'd10);
    send_event(OP_CALL, 8'h00, 64'd50, 64'd5);
    send_event(OP_CALL, 8'h00, 64'd200, 64'd500);
    send_event(OP_RET, 8'h00, 64'd300, 64'd100);
    send_event(OP_RET, 8'h00, 64'd250, 64'd900);
    send_event(OP_CALL, 8'hAA, '0, '0);
    send_event(OP_CALL, 8'h55, '1, '1);
    send_event(OP_TAIL, 8'h55, '1, '1);
    send_event(OP_RET, 8'h00, 64'd1, '1);
    send_event(OP_CALL, 8'hAA, '0, '0);
    send_event(OP_TAIL, 8'h12, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_event(OP_RET, 8'h00, '1, '1);
    send_event(OP_READ, 8'hAA, '0, '0);
    send_event(OP_READ, 8'hFF, '0, '0);
    send_event(OP_RET, 8'h00, '1, '1);
    send_event(OP_RET, 8'h00, '1, '1);
    clock_ns = 64'd1000;
    mem_now = 64'd1000;

    // random: call bursts to overflow, unwinds, tails, reads, noise
    while (n_events < 1140) begin
      k = $urandom_range(0, 9);
      if (k < 2) begin
        burst = $urandom_range(1, (k == 0) ? 70 : 10);
        for (int i = 0; i < burst; i++) begin
          step_clock();
          send_event(OP_CALL, 8'($urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 7)),
                     clock_ns, mem_now, $urandom_range(0, 1));
        end
      end else if (k < 4) begin
        burst = $urandom_range(1, (level > 0) ? level + 1 : 2);
        for (int i = 0; i < burst; i++) begin
          step_clock();
          send_event(OP_RET, 8'($urandom), clock_ns, mem_now, $urandom_range(0, 1));
        end
      end else if (k < 6) begin
        step_clock();
        send_event(OP_TAIL, 8'($urandom_range(0, 7)), clock_ns, mem_now);
      end else if (k < 8) begin
        step_clock();
        send_event(OP_READ, 8'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7)),
                   clock_ns, mem_now);
      end else begin
        step_clock();
        fid = 8'($urandom);
        send_event(op_t'($urandom_range(0, 3)), fid, rand64(), rand64());
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d events (call bursts past stack overflow, unwinds, tail calls, reads),",
             n_events);
    $display("checked %0d record beats, %0d mismatches.", beats_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
